/* rtl/abf_pkg.sv */
// abf_pkg: shared types and constants for the adc boxcar filter with low alarm
// no dependencies; imported by every module under rtl
`timescale 1ns / 1ps

package abf_pkg;

    // fixed sample and field widths
    localparam int SAMPLE_BITS      = 12;
    localparam int LIMIT_BITS       = 12;
    localparam int TDATA_BITS       = 40;   // three 12-bit fields padded to bytes
    localparam int WINDOW_SIZE_DEF  = 8;
    localparam logic [LIMIT_BITS-1:0] LOW_LIMIT_RESET = LIMIT_BITS'(100);

    // divider: the mean never exceeds the largest sample, so the quotient
    // needs SAMPLE_BITS bits, resolved DIV_BITS_PER_STEP bits per divider step
    localparam int DIV_BITS_PER_STEP = 2;
    localparam int DIV_STEPS  = (SAMPLE_BITS + DIV_BITS_PER_STEP - 1) / DIV_BITS_PER_STEP;
    localparam int QUO_W      = DIV_STEPS * DIV_BITS_PER_STEP;
    localparam int STEP_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_OUTPUT
    } abf_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming item
        logic update;    // ring write, sum update, divider load
        logic div_step;  // one divider iteration
        logic out_load;  // move the result into the output register
    } abf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;  // output register holds an item not taken this cycle
    } abf_stat_t;

endpackage

/* rtl/abf_div.sv */
// abf_div: iterative restoring divider, DIV_BITS_PER_STEP quotient bits a cycle
// while step is high; depends on abf_pkg
`timescale 1ns / 1ps

module abf_div
    import abf_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  logic                                      aclk,
    input  logic                                      load,
    input  logic                                      step,
    input  logic [SAMPLE_BITS+$clog2(WINDOW_SIZE)-1:0] dividend,
    input  logic [$clog2(WINDOW_SIZE+1)-1:0]          divisor,
    output logic [QUO_W-1:0]                          quotient
);

    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int REM_W = CNT_W + 1;

    logic [REM_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] dvd_reg, dvd_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] dvs_reg;

    // upper dividend bits are below the divisor since the quotient fits QUO_W bits
    always_comb begin
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] dvs_ext;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        quo_next = quo_reg;
        dvs_ext  = REM_W'(dvs_reg);
        for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
            trial    = {rem_next[REM_W-2:0], dvd_next[QUO_W-1]};
            dvd_next = {dvd_next[QUO_W-2:0], 1'b0};
            if (trial >= dvs_ext) begin
                rem_next = trial - dvs_ext;
                quo_next = {quo_next[QUO_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_next[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg <= REM_W'(dividend >> QUO_W);
            dvd_reg <= dividend[QUO_W-1:0];
            quo_reg <= '0;
            dvs_reg <= divisor;
        end else if (step) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;

endmodule

/* rtl/abf_datapath.sv */
// abf_datapath: sample ring, running sum, fill count, divider and output register
// depends on abf_pkg and abf_div
`timescale 1ns / 1ps

module abf_datapath
    import abf_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  abf_cmd_t               cmd,
    output abf_stat_t              stat,
    input  logic                   cfg_wr_en,
    input  logic [LIMIT_BITS-1:0]  cfg_wr_data,
    input  logic [TDATA_BITS-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_BITS-1:0]  m_tdata,
    output logic                   m_tuser
);

    localparam int IDX_W = $clog2(WINDOW_SIZE);
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_SIZE);

    logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_SIZE];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    logic [LIMIT_BITS-1:0]  low_limit_reg;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0] ch0_reg, ch1_reg, ch2_reg;
    logic                   alarm_reg;
    logic                   full;
    logic [SAMPLE_BITS-1:0] oldest;
    logic [QUO_W-1:0]       mean;

    logic                   m_tvalid_reg;
    logic [TDATA_BITS-1:0]  m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg;

    // ring: slots past the fill count were never written and count as zero
    always_ff @(posedge aclk) begin
        rd_data_reg <= ring_mem[slot_reg];
        if (cmd.update) begin
            ring_mem[slot_reg] <= ch1_reg;
        end
    end

    assign full      = (fill_reg == CNT_W'(WINDOW_SIZE));
    assign oldest    = full ? rd_data_reg : '0;
    assign sum_next  = sum_reg - SUM_W'(oldest) + SUM_W'(ch1_reg);
    assign slot_next = (slot_reg == IDX_W'(WINDOW_SIZE - 1)) ? '0 : slot_reg + 1'b1;
    assign fill_next = full ? fill_reg : fill_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_limit_reg <= LOW_LIMIT_RESET;
            slot_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                low_limit_reg <= cfg_wr_data;
            end
            if (cmd.update) begin
                slot_reg <= slot_next;
                fill_reg <= fill_next;
                sum_reg  <= sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ch0_reg   <= s_tdata[SAMPLE_BITS-1:0];
            ch1_reg   <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            ch2_reg   <= s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
            alarm_reg <= (s_tdata[SAMPLE_BITS-1:0] < low_limit_reg);
        end
    end

    abf_div #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_div (
        .aclk     (aclk),
        .load     (cmd.update),
        .step     (cmd.div_step),
        .dividend (sum_next),
        .divisor  (fill_next),
        .quotient (mean)
    );

    // alarm items carry zero data
    always_comb begin
        m_tdata_next = '0;
        if (!alarm_reg) begin
            m_tdata_next[SAMPLE_BITS-1:0]             = ch0_reg;
            m_tdata_next[2*SAMPLE_BITS-1:SAMPLE_BITS] = mean[SAMPLE_BITS-1:0];
            m_tdata_next[3*SAMPLE_BITS-1:2*SAMPLE_BITS] = ch2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= alarm_reg;
        end
    end

    assign stat.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign m_tuser       = m_tuser_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(WINDOW_SIZE))
        else $error("fill count beyond window");

    a_slot_tracks_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        !full |-> (slot_reg == IDX_W'(fill_reg)))
        else $error("write slot out of step with fill count during warm-up");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !stat.out_busy)
        else $error("output register overwritten while held");

    a_alarm_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg) |-> (m_tdata_reg == '0))
        else $error("alarm item carries data");

endmodule

/* rtl/abf_ctrl.sv */
// abf_ctrl: sequencer for one item: capture, ring update, divide, hand-off
// depends on abf_pkg
`timescale 1ns / 1ps

module abf_ctrl
    import abf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output abf_cmd_t  cmd,
    input  abf_stat_t stat
);

    abf_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                step_next  = '0;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE) |-> (step_reg < STEP_W'(DIV_STEPS)))
        else $error("divider step count overrun");

    a_update_after_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> cmd.update)
        else $error("captured item not followed by ring update");

    a_load_after_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> $past(state_reg == ST_DIVIDE) || $past(state_reg == ST_OUTPUT))
        else $error("result loaded without a finished division");

endmodule

/* rtl/adc_boxcar_filter_with_low_alarm.sv */
// adc_boxcar_filter_with_low_alarm: top level, WINDOW_SIZE-sample boxcar on channel one
// (default 8) with a channel-zero low alarm; depends on abf_pkg, abf_ctrl, abf_datapath
`timescale 1ns / 1ps

//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------------
//  s_       | in        | tdata: ch0_sample[11:0], ch1_sample[23:12], ch2_sample[35:24]
//  m_       | out       | tdata: ch0_out, ch1_filtered, ch2_out as above; tuser: alarm
//  cfg_     | in        | cfg_wr_data: low_limit, written when cfg_wr_en is high
//
//  an accepted item passes through capture, ring update, the divider and the output
//  register; the divider resolves two quotient bits a cycle
//  the next item is accepted the cycle after the result enters the output register
//  reset is synchronous and active low; low_limit returns to 100, ring counts as empty
//  a stalled m_ side holds the result in the output register and holds s_tready low
//  only once the following item has been divided

module adc_boxcar_filter_with_low_alarm
    import abf_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // low limit register
    input  logic                  cfg_wr_en,
    input  logic [LIMIT_BITS-1:0] cfg_wr_data,

    // sample sets in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_BITS-1:0] s_tdata,   // ch0_sample, ch1_sample, ch2_sample, zero pad

    // results out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata,   // ch0_out, ch1_filtered, ch2_out, zero pad
    output logic                  m_tuser    // alarm
);

    abf_cmd_t  cmd;
    abf_stat_t stat;

    // sequencer: one item in flight from capture to output register
    abf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // ring memory, running sum, divider and the output register
    abf_datapath #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

/* tb/sv/adc_boxcar_filter_with_low_alarm_test.sv */
// adc_boxcar_filter_with_low_alarm_test: self-checking bench for the boxcar filter
// with low alarm, built from a queue-fed item driver, a result monitor and a bench-side filter model
// depends on abf_pkg and the adc_boxcar_filter_with_low_alarm top level
`timescale 1ns / 1ps

module adc_boxcar_filter_with_low_alarm_test;
    import abf_pkg::*;

    // filter geometry as instantiated (default window)
    localparam int WINDOW      = WINDOW_SIZE_DEF;
    localparam int SLOT_BITS   = $clog2(WINDOW);
    localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;
    localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;

    // flush wait: one item's pass from acceptance to result, plus some slack for the drain
    localparam int FLUSH_CYCLES = 3 + DIV_STEPS + 16;
    localparam int SHOW_LIMIT   = 10;
    localparam int GAP_PERCENT  = 17;
    localparam int PHASES       = 6;
    localparam int ITEMS_PER_PHASE = 272;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    // one adc scan: the three raw channel samples
    typedef struct packed {
        sample_t ch0;
        sample_t ch1;
        sample_t ch2;
    } scan_t;

    // one filter result as seen on the m_ side
    typedef struct packed {
        logic    alarm;
        sample_t ch0;
        sample_t ch1_mean;
        sample_t ch2;
    } filter_out_t;

    // dut signals, all inputs known from time zero
    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [LIMIT_BITS-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [TDATA_BITS-1:0] s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;
    logic                  m_tuser;

    // bench-side copy of the filter state and the low limit register
    sample_t               ring [WINDOW];
    logic [SUM_BITS-1:0]   ring_sum;
    logic [SLOT_BITS-1:0]  ring_slot;
    logic [SLOT_BITS:0]    ring_fill;
    logic [LIMIT_BITS-1:0] alarm_limit;

    // scans waiting to be driven, and results the filter still owes us
    scan_t       pending_scans[$];
    filter_out_t owed_results[$];

    // when set, neither side inserts gaps or stalls
    logic no_gaps = 1'b0;

    int scans_sent     = 0;
    int results_seen   = 0;
    int alarms_seen    = 0;
    int failures       = 0;
    int limit_settings = 1;

    adc_boxcar_filter_with_low_alarm uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // ch0_sample, ch1_sample, ch2_sample, zero pad
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),     // ch0_out, ch1_filtered, ch2_out, zero pad
        .m_tuser     (m_tuser)      // alarm
    );

    always #4 aclk = ~aclk;

    // advance the bench filter by one scan and return what the block must send back
    function automatic filter_out_t boxcar_step(scan_t scan);
        filter_out_t         result;
        logic [SUM_BITS-1:0] mean;
        // oldest sample leaves the sum, the new one enters; the sum never leaves its width
        ring_sum = ring_sum - SUM_BITS'(ring[ring_slot]) + SUM_BITS'(scan.ch1);
        ring[ring_slot] = scan.ch1;
        ring_slot = ring_slot + 1'b1;
        if (ring_fill < WINDOW) begin
            ring_fill = ring_fill + 1'b1;
        end
        // during warm-up the divisor is the count including this scan, never zero
        mean = ring_sum / SUM_BITS'(ring_fill);
        result = '0;
        if (scan.ch0 < alarm_limit) begin
            // alarm: the filter has still moved, but the data fields read as zero
            result.alarm = 1'b1;
        end else begin
            result.ch0      = scan.ch0;
            result.ch1_mean = mean[SAMPLE_BITS-1:0];
            result.ch2      = scan.ch2;
        end
        return result;
    endfunction

    // item driver: holds an item until taken, then maybe idles before the next one
    always @(posedge aclk) begin : drive_scans
        scan_t offered;
        scan_t next_scan;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            foreach (ring[i]) begin
                ring[i] = '0;
            end
            ring_sum    = '0;
            ring_slot   = '0;
            ring_fill   = '0;
            alarm_limit = LOW_LIMIT_RESET;
        end else begin
            // register writes only happen while nothing is in flight
            if (cfg_wr_en) begin
                alarm_limit = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                offered.ch0 = s_tdata[SAMPLE_BITS-1:0];
                offered.ch1 = s_tdata[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
                offered.ch2 = s_tdata[3*SAMPLE_BITS-1 -: SAMPLE_BITS];
                owed_results.push_back(boxcar_step(offered));
                scans_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_scans.size() != 0 &&
                    (no_gaps || $urandom_range(99) >= GAP_PERCENT)) begin
                    next_scan = pending_scans.pop_front();
                    s_tdata   <= TDATA_BITS'({next_scan.ch2, next_scan.ch1, next_scan.ch0});
                    s_tvalid  <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: random back-pressure, every taken item checked against the oldest owed one
    always @(posedge aclk) begin : check_results
        filter_out_t got;
        filter_out_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.alarm    = m_tuser;
                got.ch0      = m_tdata[SAMPLE_BITS-1:0];
                got.ch1_mean = m_tdata[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
                got.ch2      = m_tdata[3*SAMPLE_BITS-1 -: SAMPLE_BITS];
                results_seen++;
                if (got.alarm === 1'b1) begin
                    alarms_seen++;
                end
                if (owed_results.size() == 0) begin
                    failures++;
                    if (failures <= SHOW_LIMIT) begin
                        $display("%0t: result %0d arrived with none owed (alarm %0b ch0 %0d mean %0d ch2 %0d)",
                                 $realtime, results_seen, got.alarm, got.ch0, got.ch1_mean, got.ch2);
                    end
                end else begin
                    want = owed_results.pop_front();
                    if (got.alarm !== want.alarm || got.ch0 !== want.ch0 ||
                        got.ch1_mean !== want.ch1_mean || got.ch2 !== want.ch2) begin
                        failures++;
                        if (failures <= SHOW_LIMIT) begin
                            $display("%0t: result %0d expected alarm %0b ch0 %0d mean %0d ch2 %0d",
                                     $realtime, results_seen, want.alarm, want.ch0,
                                     want.ch1_mean, want.ch2);
                            $display("%0t: result %0d actual   alarm %0b ch0 %0d mean %0d ch2 %0d",
                                     $realtime, results_seen, got.alarm, got.ch0,
                                     got.ch1_mean, got.ch2);
                        end
                    end
                end
            end
            m_tready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
        end
    end

    // block until the driver is empty and every owed result has come back
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (pending_scans.size() != 0 || s_tvalid || owed_results.size() != 0);
    endtask

    initial begin : stimulus
        int directed [20][3];
        int limits [PHASES];
        scan_t fresh;
        int run_style;
        int run_left;
        int level;
        int roll;
        logic [LIMIT_BITS-1:0] limit;

        // directed scans at the reset limit of 100, starting on an empty ring
        directed = '{
            '{100,  4095, 0},      // exactly at the limit: data, warm-up divisor 1
            '{4095, 4094, 4095},   // warm-up mean truncates (8189 / 2)
            '{99,   4095, 4095},   // one below the limit: alarm, ring still updates
            '{0,    4095, 0},      // lowest ch0: alarm
            '{4095, 4095, 2730},
            '{101,  4095, 1365},
            '{2048, 4095, 4095},
            '{4095, 4095, 0},      // window now full
            '{4095, 4095, 4095},   // window holds 4094 and seven full-scale samples, largest sum
            '{4095, 0,    4095},   // start draining the window
            '{2000, 0,    0},
            '{2001, 0,    4095},
            '{300,  0,    0},
            '{3000, 0,    4095},
            '{1234, 0,    0},
            '{4000, 0,    4095},
            '{100,  0,    0},
            '{4095, 0,    0},      // window all zero
            '{4095, 7,    4095},   // mean truncates to zero
            '{1,    4095, 0}       // alarm while the ring moves
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i]) begin
            fresh.ch0 = sample_t'(directed[i][0]);
            fresh.ch1 = sample_t'(directed[i][1]);
            fresh.ch2 = sample_t'(directed[i][2]);
            pending_scans.push_back(fresh);
        end
        // sender holds off here until the block has returned everything
        wait_drained();

        // limit settings: both extremes, a midpoint, a random one, one and back to reset
        limits = '{0, SAMPLE_MAX, 2048, $urandom_range(SAMPLE_MAX), 1, 100};
        run_left = 0;
        run_style = 0;
        level = 0;
        for (int phase = 0; phase < PHASES; phase++) begin
            limit = LIMIT_BITS'(limits[phase]);
            @(posedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= limit;
            @(posedge aclk);
            cfg_wr_en   <= 1'b0;
            @(negedge aclk);
            limit_settings++;
            // one phase runs back to back with no gaps and no stalls
            no_gaps = (phase == 2);

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // ch1 comes in runs so the window fills with noise, extremes or a steady level
                if (run_left == 0) begin
                    run_style = $urandom_range(3);
                    run_left  = $urandom_range(1, 12);
                    level     = $urandom_range(SAMPLE_MAX);
                end
                run_left--;
                case (run_style)
                    0: begin
                        fresh.ch1 = sample_t'($urandom_range(SAMPLE_MAX));
                    end
                    1: begin
                        fresh.ch1 = sample_t'(SAMPLE_MAX);
                    end
                    2: begin
                        fresh.ch1 = '0;
                    end
                    default: begin
                        fresh.ch1 = sample_t'(level ^ $urandom_range(15));
                    end
                endcase

                // ch0 lands on and just under the limit often, extremes sometimes
                roll = $urandom_range(99);
                if (roll < 15) begin
                    fresh.ch0 = (limit == 0) ? sample_t'(0) : sample_t'(limit - 1'b1);
                end else if (roll < 30) begin
                    fresh.ch0 = sample_t'(limit);
                end else if (roll < 40) begin
                    fresh.ch0 = $urandom_range(1) ? sample_t'(SAMPLE_MAX) : sample_t'(0);
                end else begin
                    fresh.ch0 = sample_t'($urandom_range(SAMPLE_MAX));
                end

                roll = $urandom_range(99);
                if (roll < 10) begin
                    fresh.ch2 = $urandom_range(1) ? sample_t'(SAMPLE_MAX) : sample_t'(0);
                end else begin
                    fresh.ch2 = sample_t'($urandom_range(SAMPLE_MAX));
                end
                pending_scans.push_back(fresh);
            end
            wait_drained();
        end
        no_gaps = 1'b0;

        // let anything stray come out before judging
        repeat (FLUSH_CYCLES) @(posedge aclk);
        if (owed_results.size() != 0) begin
            failures++;
            $display("%0d results never arrived", owed_results.size());
        end

        $display("drove %0d adc scans and checked %0d results (%0d alarms, %0d data)",
                 scans_sent, results_seen, alarms_seen, results_seen - alarms_seen);
        $display("across %0d low limit settings including 0 and full scale, %0d failures",
                 limit_settings, failures);
        if (failures == 0) begin
            $display("adc_boxcar_filter_with_low_alarm_test passed");
        end else begin
            $display("adc_boxcar_filter_with_low_alarm_test failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d results still owed", owed_results.size());
        $display("adc_boxcar_filter_with_low_alarm_test failed");
        $finish;
    end

endmodule
